// ===== design/lpli_pkg.sv =====
// ----------------------------------------------------------------------------
// lpli_pkg: shared types and constants for the literal pool lookup/insert block
// Table sizing, request and status codes, transaction payloads, sequencer
// states and the control/status bundles between the sequencer and the scanner.
// ----------------------------------------------------------------------------
package lpli_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int WORD_WIDTH  = 32;

   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

   // fixed field widths of the transaction payloads
   localparam int REQ_TYPE_W  = 3;
   localparam int VALUE_W     = 32;
   localparam int STATUS_W    = 2;
   localparam int OFFSET_W    = 8;
   localparam int ENTRY_CNT_W = 9;

   localparam logic [REQ_TYPE_W-1:0] REQ_LOOKUP = 3'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_FIND   = 3'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_START  = 3'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_NEXT   = 3'd3;
   localparam logic [REQ_TYPE_W-1:0] REQ_END    = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RUNNING = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NO_NEXT = 2'd3;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0]    req_type;
      logic signed [VALUE_W-1:0] lookup_value;
   } lpli_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic                      found;
      logic [OFFSET_W-1:0]       entry_offset;
      logic signed [VALUE_W-1:0] read_value;
      logic [ENTRY_CNT_W-1:0]    entry_count;
      logic                      has_next;
      logic                      is_empty;
   } lpli_rsp_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_READ,
      S_DONE
   } lpli_state_type;

   typedef struct packed {
      logic start;   // rewind the scan to entry zero
      logic run;     // scan in progress
   } lpli_scan_ctl_type;

   typedef struct packed {
      logic              hit;
      logic              miss;
      logic [ADDR_W-1:0] idx;
   } lpli_scan_stat_type;

endpackage

// ===== design/literal_pool_lookup_insert_top.sv =====
// Lookup/find: one RAM read and one compare per stored entry, ending at the first hit, or
//   at a miss once the last stored entry has compared unequal or the table is empty.
// Start/end, unused codes and next with no entry go straight to the result; next with an
//   entry first reads the word at the cursor.
// One transaction in flight; the next is accepted the cycle after the result moves to the
// output register, which may still be waiting on rsp_stall. Reset clears count, cursor, flag.
// ----------------------------------------------------------------------------
// literal_pool_lookup_insert_top: deduplicating literal pool
// Sequencer, sequential compare unit and word RAM, with a registered result.
// ----------------------------------------------------------------------------
module literal_pool_lookup_insert_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  lpli_pkg::lpli_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output lpli_pkg::lpli_rsp_type rsp_data
);
   import lpli_pkg::*;

   lpli_scan_ctl_type     scan_ctl;
   lpli_scan_stat_type    scan_stat;
   logic [ADDR_W-1:0]     scan_addr;
   logic [WORD_WIDTH-1:0] key;
   logic [CNT_W-1:0]      count;
   logic                  ram_wr_en;
   logic [ADDR_W-1:0]     ram_wr_addr;
   logic [ADDR_W-1:0]     ram_rd_addr;
   logic [WORD_WIDTH-1:0] ram_rd_data;
   logic                  res_valid;
   lpli_rsp_type          res_data;
   logic                  res_take;

   logic                  rsp_valid_ff, rsp_valid_in;
   lpli_rsp_type          rsp_data_ff, rsp_data_in;

   lpli_ram #(
      .WIDTH (WORD_WIDTH),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (key),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   lpli_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .ctl     (scan_ctl),
      .key     (key),
      .count   (count),
      .rd_data (ram_rd_data),
      .rd_addr (scan_addr),
      .stat    (scan_stat)
   );

   lpli_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_data    (req_data),
      .req_stall   (req_stall),
      .scan_ctl    (scan_ctl),
      .scan_stat   (scan_stat),
      .scan_addr   (scan_addr),
      .key         (key),
      .count       (count),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .res_valid   (res_valid),
      .res_data    (res_data),
      .res_take    (res_take)
   );

   // output register: loads when empty or being drained this cycle
   assign res_take = res_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("block accepted a transaction but did not go busy");

   a_next_needs_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.has_next |-> !rsp_data.is_empty)
      else $error("cursor active on an empty table");

   a_full_at_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ST_FULL) |->
         rsp_data.entry_count == ENTRY_CNT_W'(TABLE_DEPTH))
      else $error("table full reported below capacity");

   a_found_is_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.found |-> rsp_data.status == ST_OK)
      else $error("hit reported with an error status");

endmodule

// ===== design/lpli_ram.sv =====
// ----------------------------------------------------------------------------
// lpli_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module lpli_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/lpli_scan.sv =====
// ----------------------------------------------------------------------------
// lpli_scan: sequential compare unit
// Walks the stored entries in insertion order, one RAM read per cycle, and
// compares each returned word against the key. Reports the first hit, or a
// miss once the last stored entry has been compared, or at once if the table is empty.
// ----------------------------------------------------------------------------
module lpli_scan (
   input  logic                           clock,
   input  logic                           reset,
   input  lpli_pkg::lpli_scan_ctl_type    ctl,
   input  logic [lpli_pkg::WORD_WIDTH-1:0] key,
   input  logic [lpli_pkg::CNT_W-1:0]     count,
   input  logic [lpli_pkg::WORD_WIDTH-1:0] rd_data,
   output logic [lpli_pkg::ADDR_W-1:0]    rd_addr,
   output lpli_pkg::lpli_scan_stat_type   stat
);
   import lpli_pkg::*;

   logic [CNT_W-1:0]  scan_addr_ff, scan_addr_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [ADDR_W-1:0] pend_idx_ff, pend_idx_in;
   logic              issue;
   logic              match;
   logic              last_pend;

   assign issue     = ctl.run && (scan_addr_ff < count);
   assign match     = pend_valid_ff && (rd_data == key);
   assign last_pend = (CNT_W'(pend_idx_ff) + CNT_W'(1)) == count;

   always_comb begin
      scan_addr_in  = scan_addr_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      if (ctl.start) begin
         scan_addr_in  = '0;
         pend_valid_in = 1'b0;
      end else if (ctl.run) begin
         pend_valid_in = issue;
         pend_idx_in   = ADDR_W'(scan_addr_ff);
         if (issue) begin
            scan_addr_in = scan_addr_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_addr_ff  <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         scan_addr_ff  <= scan_addr_in;
         pend_valid_ff <= pend_valid_in;
      end
      pend_idx_ff <= pend_idx_in;
   end

   assign rd_addr   = ADDR_W'(scan_addr_ff);
   assign stat.hit  = ctl.run && match;
   // empty table misses at once; otherwise after the last entry compares unequal
   assign stat.miss = ctl.run && ((count == '0) || (pend_valid_ff && !match && last_pend));
   assign stat.idx  = pend_idx_ff;

endmodule

// ===== design/lpli_ctrl.sv =====
// ----------------------------------------------------------------------------
// lpli_ctrl: request sequencer and pool state
// Holds the entry count and iteration cursor, steers the scanner and the
// RAM, performs inserts and cursor reads, and stages each result.
// ----------------------------------------------------------------------------
module lpli_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  lpli_pkg::lpli_req_type          req_data,
   output logic                            req_stall,
   output lpli_pkg::lpli_scan_ctl_type     scan_ctl,
   input  lpli_pkg::lpli_scan_stat_type    scan_stat,
   input  logic [lpli_pkg::ADDR_W-1:0]     scan_addr,
   output logic [lpli_pkg::WORD_WIDTH-1:0] key,
   output logic [lpli_pkg::CNT_W-1:0]      count,
   output logic                            ram_wr_en,
   output logic [lpli_pkg::ADDR_W-1:0]     ram_wr_addr,
   output logic [lpli_pkg::ADDR_W-1:0]     ram_rd_addr,
   input  logic [lpli_pkg::WORD_WIDTH-1:0] ram_rd_data,
   output logic                            res_valid,
   output lpli_pkg::lpli_rsp_type          res_data,
   input  logic                            res_take
);
   import lpli_pkg::*;

   lpli_state_type          state_ff, state_in;
   logic [REQ_TYPE_W-1:0]   req_ff, req_in;
   logic [WORD_WIDTH-1:0]   key_ff, key_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [ADDR_W-1:0]       cursor_ff, cursor_in;
   logic                    active_ff, active_in;
   logic [STATUS_W-1:0]     status_ff, status_in;
   logic                    found_ff, found_in;
   logic [ADDR_W-1:0]       offset_ff, offset_in;
   logic [WORD_WIDTH-1:0]   read_ff, read_in;
   logic                    accept;
   logic                    next_ok;

   assign accept  = req_valid && (state_ff == S_IDLE);
   assign next_ok = active_ff && (CNT_W'(cursor_ff) < count_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_data.req_type)
                  REQ_LOOKUP, REQ_FIND: state_in = S_SCAN;
                  REQ_NEXT:             state_in = next_ok ? S_READ : S_DONE;
                  default:              state_in = S_DONE;
               endcase
            end
         end
         S_SCAN: begin
            if (scan_stat.hit || scan_stat.miss) begin
               state_in = S_DONE;
            end
         end
         S_READ: state_in = S_DONE;
         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_in    = req_ff;
      key_in    = key_ff;
      count_in  = count_ff;
      cursor_in = cursor_ff;
      active_in = active_ff;
      status_in = status_ff;
      found_in  = found_ff;
      offset_in = offset_ff;
      read_in   = read_ff;
      ram_wr_en = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in    = req_data.req_type;
               key_in    = WORD_WIDTH'($unsigned(req_data.lookup_value));
               status_in = ST_OK;
               found_in  = 1'b0;
               offset_in = '0;
               read_in   = '0;
               case (req_data.req_type)
                  REQ_START: begin
                     if (active_ff) begin
                        status_in = ST_RUNNING;
                     end else begin
                        cursor_in = '0;
                        active_in = (count_ff != '0);
                     end
                  end
                  REQ_NEXT: begin
                     if (!next_ok) begin
                        active_in = 1'b0;
                        status_in = ST_NO_NEXT;
                     end
                  end
                  REQ_END: begin
                     active_in = 1'b0;
                     cursor_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         S_SCAN: begin
            if (scan_stat.hit) begin
               found_in  = 1'b1;
               offset_in = scan_stat.idx;
            end else if (scan_stat.miss && (req_ff == REQ_LOOKUP)) begin
               if (count_ff >= CNT_W'(TABLE_DEPTH)) begin
                  status_in = ST_FULL;
               end else begin
                  ram_wr_en = 1'b1;
                  offset_in = ADDR_W'(count_ff);
                  count_in  = count_ff + CNT_W'(1);
               end
            end
         end
         S_READ: begin
            // read data is for the cursor address presented in the accept cycle
            read_in   = ram_rd_data;
            offset_in = cursor_ff;
            cursor_in = cursor_ff + ADDR_W'(1);
            if ((CNT_W'(cursor_ff) + CNT_W'(1)) >= count_ff) begin
               active_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         cursor_ff <= '0;
         active_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         cursor_ff <= cursor_in;
         active_ff <= active_in;
      end
      req_ff    <= req_in;
      key_ff    <= key_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      offset_ff <= offset_in;
      read_ff   <= read_in;
   end

   always_comb begin
      req_stall      = (state_ff != S_IDLE);
      scan_ctl.start = accept;
      scan_ctl.run   = (state_ff == S_SCAN);
      ram_rd_addr    = (state_ff == S_SCAN) ? scan_addr : cursor_ff;
      ram_wr_addr    = ADDR_W'(count_ff);
      key            = key_ff;
      count          = count_ff;
      res_valid      = (state_ff == S_DONE);
      res_data.status       = status_ff;
      res_data.found        = found_ff;
      res_data.entry_offset = OFFSET_W'(offset_ff);
      res_data.read_value   = $signed(VALUE_W'(read_ff));
      res_data.entry_count  = ENTRY_CNT_W'(count_ff);
      res_data.has_next     = active_ff;
      res_data.is_empty     = (count_ff == '0);
   end

endmodule
